[sv/lfu_pkg.sv]
// Shared types and constants for the LFU cache table.
package lfu_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W  = 5;

  // Operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef logic [DATA_W-1:0] word_t;

  localparam word_t MISS_DATA = '1;
  localparam word_t PUT_DATA  = '0;
  localparam word_t CNT_MAX   = '1;
  localparam word_t CNT_ONE   = word_t'(1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

endpackage

[sv/lfu_mem.sv]
// Simple dual-port entry memory: one write and one registered read per cycle.
module lfu_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned W     = 100
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[sv/lfu_cache_table.sv]
// LFU cache table top level: sequencer over the entry memory.
// A transaction is taken when start is high and busy is low; its one result
// is shown for a single cycle with done and cannot be held off. Entries live
// in one memory that is read one entry per cycle; a miss that needs no update
// takes one pass over the occ filled entries (occ is at most ENTRIES), and a
// hit or a replacement takes that pass and then an update pass over them.
// Filled slots are always the lowest occ slots, so the fill count serves as
// the valid state; no clearing pass follows reset.
module lfu_cache_table #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [31:0] key,
  input  logic [31:0] data_in,
  output logic        done,
  output logic        hit,
  output logic [31:0] data_out,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned XW = (CW > lfu_pkg::CAP_W) ? CW : lfu_pkg::CAP_W;
  localparam int unsigned DW = lfu_pkg::DATA_W;
  localparam int unsigned W  = 3 * DW + AW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_UPD    = 3'd3;

  logic [2:0]    state;
  logic [4:0]    capacity;
  logic [CW-1:0] occ;
  logic [CW-1:0] icnt;
  logic          rv;
  logic [AW-1:0] rq;

  logic          op_q;
  lfu_pkg::word_t key_q, din_q;

  logic          found, have;
  logic [AW-1:0] fidx, vidx, tgt;
  lfu_pkg::word_t fval, fcnt, vcnt, tval, tcnt;
  logic [AW-1:0] frank, vrank, oldrank;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [W-1:0]  wdata, rdata;

  lfu_pkg::word_t r_key, r_val, r_cnt;
  logic [AW-1:0]  r_rank;
  logic           issue, scan_end, room;
  logic [AW-1:0]  top_rank;

  assign {r_key, r_val, r_cnt, r_rank} = rdata;
  assign issue    = (icnt < occ);
  assign scan_end = !issue && !rv;
  assign room     = (XW'(occ) < XW'(capacity)) && (occ < CW'(ENTRIES));
  assign top_rank = AW'(occ - CW'(1));
  assign raddr    = icnt[AW-1:0];
  assign busy     = (state != S_IDLE);

  lfu_mem #(.DEPTH(ENTRIES), .AW(AW), .W(W)) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Write port: fill write in DECIDE, read-modify-write in UPD
  always_comb begin
    we    = 1'b0;
    waddr = rq;
    wdata = rdata;
    if (state == S_DECIDE) begin
      waddr = occ[AW-1:0];
      wdata = {key_q, din_q, lfu_pkg::CNT_ONE, occ[AW-1:0]};
      we    = (op_q == lfu_pkg::OP_PUT) && !found && (capacity != 5'd0) && room;
    end else if (state == S_UPD && rv) begin
      we = 1'b1;
      if (rq == tgt) begin
        wdata = {key_q, tval, tcnt, top_rank};
      end else if (r_rank > oldrank) begin
        wdata = {r_key, r_val, r_cnt, r_rank - AW'(1)};
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lfu_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // Read pipeline tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else begin
      rv <= (state == S_SCAN || state == S_UPD) && issue;
    end
    rq <= raddr;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
      done  <= 1'b0;
      icnt  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SCAN;
            icnt  <= '0;
            found <= 1'b0;
            have  <= 1'b0;
            op_q  <= op;
            key_q <= key;
            din_q <= data_in;
          end
        end
        S_SCAN: begin
          if (issue) begin
            icnt <= icnt + CW'(1);
          end
          if (rv) begin
            if (!found && r_key == key_q) begin
              found <= 1'b1;
              fidx  <= rq;
              fval  <= r_val;
              fcnt  <= r_cnt;
              frank <= r_rank;
            end
            if (!have || r_cnt < vcnt || (r_cnt == vcnt && r_rank < vrank)) begin
              have  <= 1'b1;
              vidx  <= rq;
              vcnt  <= r_cnt;
              vrank <= r_rank;
            end
          end
          if (scan_end) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          hit      <= found;
          data_out <= (op_q == lfu_pkg::OP_PUT) ? lfu_pkg::PUT_DATA :
                      (found ? fval : lfu_pkg::MISS_DATA);
          icnt     <= '0;
          tgt      <= found ? fidx : vidx;
          oldrank  <= found ? frank : vrank;
          tval     <= (op_q == lfu_pkg::OP_PUT) ? din_q : fval;
          tcnt     <= !found ? lfu_pkg::CNT_ONE :
                      (fcnt == lfu_pkg::CNT_MAX) ? fcnt : fcnt + lfu_pkg::CNT_ONE;
          if (op_q == lfu_pkg::OP_GET) begin
            if (found) begin
              state <= S_UPD;
            end else begin
              state <= S_IDLE;
              done  <= 1'b1;
            end
          end else if (capacity == 5'd0) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else if (found || !room) begin
            state <= S_UPD;
          end else begin
            occ   <= occ + CW'(1);
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_UPD: begin
          if (issue) begin
            icnt <= icnt + CW'(1);
          end
          if (scan_end) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/lfu_cache_table_chk.sv]
// Port-level checker for the LFU cache table, bound to the top level.
module lfu_cache_table_chk (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        hit,
  input logic [31:0] data_out
);

  // An accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accept did not raise busy");

  // The result arrives as busy drops
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy)) else $error("done outside end of transaction");

  // No result right after acceptance
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !done) else $error("result too early");

  // A miss only gives the miss marker or the put value
  a_miss_data: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> data_out == lfu_pkg::MISS_DATA || data_out == lfu_pkg::PUT_DATA)
    else $error("bad miss data");

endmodule

bind lfu_cache_table lfu_cache_table_chk u_chk (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .hit     (hit),
  .data_out(data_out)
);
